### src/icdm_pkg.sv
// shared types and constants of the direct-mode interrupt controller
// no dependencies; used by icdm_ctrl, icdm_dp and the top level
package icdm_pkg;

	typedef struct packed {
		logic [1:0]  kind;
		logic [14:0] offset;
		logic [2:0]  access_size;
		logic [31:0] write_data;
		logic [9:0]  source;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        access_fault;
		logic        meip;
		logic        eoi_word;
		logic [31:0] eoi_mask;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;
		logic accept;
		logic scan_restart;
		logic scan_step;
		logic apply;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic scan_last;
	} stat_t;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_RAISE = 2'd2;

	localparam logic [2:0] ACCESS_BYTES = 3'd4;

	localparam logic [14:0] OFF_DOMAINCFG = 15'h0000;
	localparam logic [14:0] OFF_SETIP     = 15'h1C00;
	localparam logic [14:0] OFF_SETIPNUM  = 15'h1CDC;
	localparam logic [14:0] OFF_IN_CLRIP  = 15'h1D00;
	localparam logic [14:0] OFF_CLRIPNUM  = 15'h1DDC;
	localparam logic [14:0] OFF_SETIE     = 15'h1E00;
	localparam logic [14:0] OFF_SETIENUM  = 15'h1EDC;
	localparam logic [14:0] OFF_CLRIE     = 15'h1F00;
	localparam logic [14:0] OFF_CLRIENUM  = 15'h1FDC;
	localparam logic [14:0] OFF_IDC       = 15'h4000;
	localparam logic [2:0]  PAGE_SOURCECFG = 3'd0;
	localparam logic [2:0]  PAGE_TARGET    = 3'd3;

	localparam logic [4:0] IDC_IDELIVERY  = 5'h00;
	localparam logic [4:0] IDC_IFORCE     = 5'h04;
	localparam logic [4:0] IDC_ITHRESHOLD = 5'h08;
	localparam logic [4:0] IDC_TOPI       = 5'h18;
	localparam logic [4:0] IDC_CLAIMI     = 5'h1C;

	localparam logic [2:0] MODE_INACTIVE  = 3'd0;
	localparam logic [2:0] MODE_RSVD_A    = 3'd2;
	localparam logic [2:0] MODE_RSVD_B    = 3'd3;
	localparam logic [2:0] MODE_LEVEL_HI  = 3'd6;
	localparam logic [2:0] MODE_LEVEL_LO  = 3'd7;
	localparam int         DELEGATE_BIT   = 10;

	localparam logic [31:0] DOMAINCFG_FIXED = 32'h8000_0000;
	localparam int          DOMAINCFG_IE    = 8;

endpackage

### src/icdm_ctrl.sv
// sequencing state machine of the interrupt controller
// depends on icdm_pkg (cmd_t, stat_t)
module icdm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	output icdm_pkg::cmd_t   cmd,
	input  icdm_pkg::stat_t  stat
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_SCAN_A = 6'b000100,
		ST_APPLY  = 6'b001000,
		ST_SCAN_B = 6'b010000,
		ST_REPORT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					cmd.scan_restart = 1'b1;
					state_d = ST_SCAN_A;
				end
			end
			ST_SCAN_A: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				cmd.scan_restart = 1'b1;
				state_d = ST_SCAN_B;
			end
			ST_SCAN_B: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) state_d = ST_REPORT;
			end
			ST_REPORT: state_d = ST_IDLE;
			default: state_d = ST_CLEAR;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_REPORT);

endmodule

### src/icdm_dp.sv
// datapath: source tables, pending/enable words, domain registers, source scan
// depends on icdm_pkg
module icdm_dp #(
	parameter int NUM_SOURCES = 64,
	parameter int NUM_WORDS   = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  icdm_pkg::req_t   request,
	input  icdm_pkg::cmd_t   cmd,
	output icdm_pkg::stat_t  stat,
	output icdm_pkg::rsp_t   result
);

	localparam int IW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int WW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam logic [IW-1:0] LAST_SRC = IW'(NUM_SOURCES - 1);

	// source tables
	logic [2:0] mode_mem [NUM_SOURCES];
	logic [7:0] prio_mem [NUM_SOURCES];
	logic [2:0] mode_rd_s1;
	logic [7:0] prio_rd_s1;

	logic [IW-1:0] clr_q;
	logic [IW-1:0] scan_q;
	logic [IW-1:0] idx_s1;
	logic          vld_s1;

	icdm_pkg::req_t req_q;

	logic [NUM_WORDS-1:0][31:0] pend_q, en_q;
	logic       de_q, deliv_q, force_q;
	logic [7:0] thr_q;

	// scan accumulators
	logic          best_found_q;
	logic [IW-1:0] best_q;
	logic [7:0]    best_p_q;
	logic [31:0]   act_mask_q, lvl_mask_q;
	logic [2:0]    tgt_mode_q;
	logic [7:0]    tgt_prio_q;

	// result registers
	logic [31:0] rd_q, eoi_m_q;
	logic        fault_q, eoi_w_q;

	// request decode
	logic [14:0] off;
	logic [4:0]  wo;
	logic        rw, fault, acc_ok;
	logic        is_dom, is_scfg, is_tgt, is_setip, is_inclr, is_setie, is_clrie;
	logic        is_setipn, is_clripn, is_setien, is_clrien, is_idc;
	logic        val_lt;
	logic [9:0]  tgt;
	logic        tgt_ok;
	logic [15:0] te;
	logic [31:0] tbit;

	always_ff @(posedge clk) begin
		if (cmd.accept) req_q <= request;
	end

	assign off = req_q.offset;
	assign wo  = off[6:2];
	assign rw  = (req_q.kind == icdm_pkg::KIND_READ) || (req_q.kind == icdm_pkg::KIND_WRITE);
	assign fault = rw && ((req_q.access_size != icdm_pkg::ACCESS_BYTES) || (off[1:0] != 2'b00));
	assign acc_ok = rw && !fault;

	assign is_dom    = (off == icdm_pkg::OFF_DOMAINCFG);
	assign is_scfg   = (off[14:12] == icdm_pkg::PAGE_SOURCECFG) && !is_dom;
	assign is_tgt    = (off[14:12] == icdm_pkg::PAGE_TARGET) && (off[11:0] != 12'd0);
	assign is_setip  = (off[14:7] == icdm_pkg::OFF_SETIP[14:7]);
	assign is_inclr  = (off[14:7] == icdm_pkg::OFF_IN_CLRIP[14:7]);
	assign is_setie  = (off[14:7] == icdm_pkg::OFF_SETIE[14:7]);
	assign is_clrie  = (off[14:7] == icdm_pkg::OFF_CLRIE[14:7]);
	assign is_setipn = (off == icdm_pkg::OFF_SETIPNUM);
	assign is_clripn = (off == icdm_pkg::OFF_CLRIPNUM);
	assign is_setien = (off == icdm_pkg::OFF_SETIENUM);
	assign is_clrien = (off == icdm_pkg::OFF_CLRIENUM);
	assign is_idc    = (off[14:5] == icdm_pkg::OFF_IDC[14:5]);

	assign val_lt = (req_q.write_data < 32'(NUM_SOURCES));

	always_comb begin
		priority if (req_q.kind == icdm_pkg::KIND_RAISE) begin
			tgt = req_q.source;
			tgt_ok = (11'(req_q.source) < 11'(NUM_SOURCES));
		end else if (is_setipn || is_clripn || is_setien || is_clrien) begin
			tgt = req_q.write_data[9:0];
			tgt_ok = val_lt;
		end else begin
			tgt = off[11:2];
			tgt_ok = (11'(off[11:2]) < 11'(NUM_SOURCES));
		end
	end

	assign te = 16'(tgt);
	assign tbit = 32'(1) << te[4:0];

	// clearing pass and source scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			scan_q <= '0;
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
		end else begin
			if (cmd.clear_step && clr_q != LAST_SRC) clr_q <= clr_q + IW'(1);
			if (cmd.scan_restart) begin
				scan_q <= '0;
				vld_s1 <= 1'b0;
			end else begin
				vld_s1 <= cmd.scan_step;
				if (cmd.scan_step) begin
					idx_s1 <= scan_q;
					if (scan_q != LAST_SRC) scan_q <= scan_q + IW'(1);
				end
			end
		end
	end

	assign stat.clear_last = cmd.clear_step && (clr_q == LAST_SRC);
	assign stat.scan_last  = cmd.scan_step && vld_s1 && (idx_s1 == LAST_SRC);

	// scan stage: one source per cycle
	logic [15:0] ie;
	logic        s_act, s_pe, s_take, s_inw;
	logic [7:0]  s_p;

	assign ie    = 16'(idx_s1);
	assign s_act = (idx_s1 != '0) && (mode_rd_s1 != icdm_pkg::MODE_INACTIVE);
	assign s_inw = (ie[15:5] < 11'(NUM_WORDS));
	assign s_pe  = s_inw && pend_q[ie[5 +: WW]][ie[4:0]] && en_q[ie[5 +: WW]][ie[4:0]];
	assign s_p   = (prio_rd_s1 == 8'd0) ? 8'd1 : prio_rd_s1;
	assign s_take = s_act && s_pe && (!best_found_q || s_p < best_p_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
			best_q <= '0;
			best_p_q <= '0;
			act_mask_q <= '0;
			lvl_mask_q <= '0;
			tgt_mode_q <= '0;
			tgt_prio_q <= '0;
		end else if (cmd.scan_restart) begin
			best_found_q <= 1'b0;
			act_mask_q <= '0;
			lvl_mask_q <= '0;
			tgt_mode_q <= '0;
			tgt_prio_q <= '0;
		end else if (cmd.scan_step && vld_s1) begin
			if (s_take) begin
				best_found_q <= 1'b1;
				best_q <= idx_s1;
				best_p_q <= s_p;
			end
			if (ie[15:5] == 11'(wo) && idx_s1 != '0) begin
				act_mask_q[ie[4:0]] <= s_act;
				lvl_mask_q[ie[4:0]] <= (mode_rd_s1 == icdm_pkg::MODE_LEVEL_HI) ||
					(mode_rd_s1 == icdm_pkg::MODE_LEVEL_LO);
			end
			if (ie == te) begin
				tgt_mode_q <= mode_rd_s1;
				tgt_prio_q <= prio_rd_s1;
			end
		end
	end

	// top pending interrupt
	logic        topi_hit;
	logic [31:0] topi;
	logic [15:0] be;

	assign be = 16'(best_q);
	assign topi_hit = best_found_q && !((thr_q != 8'd0) && (best_p_q >= thr_q));
	assign topi = topi_hit ? {6'd0, be[9:0], 8'd0, best_p_q} : 32'd0;

	// apply step
	logic [15:0] aw;
	logic        aw_ok, eoi_en, mode_we, prio_we, force_clr;
	logic        de_we, deliv_we, force_we, thr_we;
	logic [31:0] pset, pclr, eset, eclr, rd, vmask, cur_pend, eoi_m;
	logic [2:0]  sm_new;
	logic [15:0] vb;

	always_comb begin
		for (int b = 0; b < 32; b++) begin
			vb = {6'd0, wo, 5'(b)};
			vmask[b] = (vb != 16'd0) && (vb < 16'(NUM_SOURCES));
		end
	end

	always_comb begin
		sm_new = req_q.write_data[2:0];
		if (req_q.write_data[icdm_pkg::DELEGATE_BIT] ||
			sm_new == icdm_pkg::MODE_RSVD_A || sm_new == icdm_pkg::MODE_RSVD_B)
			sm_new = icdm_pkg::MODE_INACTIVE;
	end

	always_comb begin
		aw = 16'(wo);
		pset = '0;
		pclr = '0;
		eset = '0;
		eclr = '0;
		rd = '0;
		eoi_en = 1'b0;
		mode_we = 1'b0;
		prio_we = 1'b0;
		force_clr = 1'b0;
		de_we = 1'b0;
		deliv_we = 1'b0;
		force_we = 1'b0;
		thr_we = 1'b0;
		if (acc_ok && req_q.kind == icdm_pkg::KIND_READ) begin
			priority if (is_dom) begin
				rd = icdm_pkg::DOMAINCFG_FIXED | (32'(de_q) << icdm_pkg::DOMAINCFG_IE);
			end else if (is_scfg) begin
				rd = 32'(tgt_mode_q);
			end else if (is_tgt) begin
				rd = (tgt_mode_q != icdm_pkg::MODE_INACTIVE) ? 32'(tgt_prio_q) : 32'd0;
			end else if (is_setip) begin
				if (aw < 16'(NUM_WORDS)) rd = pend_q[aw[WW-1:0]];
			end else if (is_setie) begin
				if (aw < 16'(NUM_WORDS)) rd = en_q[aw[WW-1:0]];
			end else if (is_inclr) begin
				if (aw < 16'(NUM_WORDS)) rd = pend_q[aw[WW-1:0]] & lvl_mask_q;
			end else if (is_idc) begin
				unique case (off[4:0])
					icdm_pkg::IDC_IDELIVERY:  rd = 32'(deliv_q);
					icdm_pkg::IDC_IFORCE:     rd = 32'(force_q);
					icdm_pkg::IDC_ITHRESHOLD: rd = 32'(thr_q);
					icdm_pkg::IDC_TOPI:       rd = topi;
					icdm_pkg::IDC_CLAIMI: begin
						rd = topi;
						if (!topi_hit) force_clr = 1'b1;
						else begin
							aw = be >> 5;
							pclr = 32'(1) << be[4:0];
							eoi_en = 1'b1;
						end
					end
					default: rd = '0;
				endcase
			end
		end else if (acc_ok) begin
			priority if (is_dom) begin
				de_we = 1'b1;
			end else if (is_scfg) begin
				if (tgt_ok) begin
					mode_we = 1'b1;
					if (sm_new == icdm_pkg::MODE_INACTIVE) begin
						aw = te >> 5;
						pclr = tbit;
						eclr = tbit;
					end
				end
			end else if (is_tgt) begin
				prio_we = tgt_ok;
			end else if (is_setip) begin
				pset = req_q.write_data & act_mask_q;
			end else if (is_inclr) begin
				pclr = req_q.write_data;
				eoi_en = 1'b1;
			end else if (is_setie) begin
				eset = req_q.write_data & vmask;
			end else if (is_clrie) begin
				eclr = req_q.write_data;
			end else if (is_setipn) begin
				aw = te >> 5;
				if (tgt_ok && tgt_mode_q != icdm_pkg::MODE_INACTIVE) pset = tbit;
			end else if (is_clripn) begin
				aw = te >> 5;
				if (tgt_ok && tgt != 10'd0) begin
					pclr = tbit;
					eoi_en = 1'b1;
				end
			end else if (is_setien || is_clrien) begin
				aw = te >> 5;
				if (tgt_ok && tgt != 10'd0) begin
					if (is_setien) eset = tbit;
					else eclr = tbit;
				end
			end else if (is_idc) begin
				unique case (off[4:0])
					icdm_pkg::IDC_IDELIVERY:  deliv_we = 1'b1;
					icdm_pkg::IDC_IFORCE:     force_we = 1'b1;
					icdm_pkg::IDC_ITHRESHOLD: thr_we = 1'b1;
					default: ;
				endcase
			end
		end else if (req_q.kind == icdm_pkg::KIND_RAISE) begin
			aw = te >> 5;
			if (tgt_ok && tgt_mode_q != icdm_pkg::MODE_INACTIVE) pset = tbit;
		end
	end

	assign aw_ok = (aw < 16'(NUM_WORDS));
	assign cur_pend = aw_ok ? pend_q[aw[WW-1:0]] : 32'd0;
	assign eoi_m = (eoi_en && aw_ok) ? (cur_pend & pclr) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			en_q <= '0;
			de_q <= 1'b0;
			deliv_q <= 1'b0;
			force_q <= 1'b0;
			thr_q <= '0;
		end else if (cmd.apply) begin
			if (aw_ok) begin
				pend_q[aw[WW-1:0]] <= (pend_q[aw[WW-1:0]] & ~pclr) | pset;
				en_q[aw[WW-1:0]] <= (en_q[aw[WW-1:0]] & ~eclr) | eset;
			end
			if (de_we) de_q <= req_q.write_data[icdm_pkg::DOMAINCFG_IE];
			if (deliv_we) deliv_q <= req_q.write_data[0];
			if (force_we) force_q <= req_q.write_data[0];
			else if (force_clr) force_q <= 1'b0;
			if (thr_we) thr_q <= req_q.write_data[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			rd_q <= rd;
			fault_q <= fault;
			eoi_m_q <= eoi_m;
			eoi_w_q <= (eoi_m != 32'd0) ? aw[0] : 1'b0;
		end
	end

	// source tables: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mode_mem[clr_q] <= icdm_pkg::MODE_INACTIVE;
			prio_mem[clr_q] <= 8'd1;
		end else if (cmd.apply) begin
			if (mode_we) mode_mem[tgt[IW-1:0]] <= sm_new;
			if (prio_we) prio_mem[tgt[IW-1:0]] <= req_q.write_data[7:0];
		end
		mode_rd_s1 <= mode_mem[scan_q];
		prio_rd_s1 <= prio_mem[scan_q];
	end

	assign result.read_data    = rd_q;
	assign result.access_fault = fault_q;
	assign result.meip         = de_q && deliv_q && (topi_hit || force_q);
	assign result.eoi_word     = eoi_w_q;
	assign result.eoi_mask     = eoi_m_q;

endmodule

### src/interrupt_controller_direct_mode_core.sv
// top level of the direct-mode interrupt controller, one domain, one hart
// depends on icdm_pkg, icdm_ctrl and icdm_dp
//
// a request is taken when start is high and busy is low; it is a 32-bit bus
// read, a bus write or a source raise event. between acceptance and done the
// source table is walked once before the access (top pending source, word
// masks and the addressed source's mode and priority) and once after it
// (meip), one source per cycle through the single read port of the
// mode/priority memory. the result is shown for exactly one cycle with done
// high and cannot be held off by the receiver. after reset the block runs a
// clearing pass over every entry of the source tables with busy high.
module interrupt_controller_direct_mode_core #(
	parameter int NUM_SOURCES = 64,
	parameter int NUM_WORDS   = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  icdm_pkg::req_t  request,
	output logic            done,
	output icdm_pkg::rsp_t  result
);

	// command and status between sequencer and datapath
	icdm_pkg::cmd_t  cmd;
	icdm_pkg::stat_t stat;

	// sequencer: clearing pass, pre-access scan, apply, post-access scan, report
	icdm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// source tables, pending/enable words and delivery control registers
	icdm_dp #(
		.NUM_SOURCES (NUM_SOURCES),
		.NUM_WORDS   (NUM_WORDS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result)
	);

	// done is never high on back-to-back cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// an accepted request keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepting a request");

	// a faulting access returns no data and reports no end-of-interrupt
	a_fault_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.access_fault) |->
			(result.read_data == 32'd0 && result.eoi_mask == 32'd0))
		else $error("faulting access returned data or eoi");

	// the eoi word is only flagged together with a nonzero mask
	a_eoi_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.eoi_word) |-> (result.eoi_mask != 32'd0))
		else $error("eoi word set with empty mask");

endmodule

### tb/icdm_checker.sv
// checker for the direct-mode interrupt controller: watches accepted requests and
// results, keeps its own copy of the controller state and compares every result
// depends on icdm_pkg
`timescale 1ns / 100ps

module icdm_checker #(
	parameter int NUM_SOURCES = 64,
	parameter int NUM_WORDS   = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  icdm_pkg::req_t  request,
	input  logic            done,
	input  icdm_pkg::rsp_t  result,
	output int              fail_count,
	output int              pending_count,
	output int              result_count
);

	localparam logic [14:0] OFF_SOURCECFG = 15'h0004;
	localparam logic [14:0] OFF_TARGET    = 15'h3004;
	localparam int          SPAN_SRC      = 4 * 1023;
	localparam int          SPAN_WORDS    = 4 * 32;

	logic [2:0]  mode_tbl [NUM_SOURCES];
	logic [7:0]  prio_tbl [NUM_SOURCES];
	logic [31:0] ip_word [NUM_WORDS];
	logic [31:0] ie_word [NUM_WORDS];
	logic        dom_ie, idelivery, iforce;
	logic [7:0]  ithreshold;
	logic        eoi_w;
	logic [31:0] eoi_m;

	icdm_pkg::rsp_t expected_rsp [$];

	function automatic bit source_live(int i);
		return i != 0 && i < NUM_SOURCES && mode_tbl[i] != icdm_pkg::MODE_INACTIVE;
	endfunction

	function automatic logic [31:0] top_source();
		int best, best_p, p;
		best = 0;
		best_p = 0;
		for (int i = 1; i < NUM_SOURCES; i++) begin
			if (i / 32 >= NUM_WORDS) break;
			if (!(ip_word[i/32][i%32] && ie_word[i/32][i%32]) || !source_live(i)) continue;
			p = (prio_tbl[i] == 0) ? 1 : prio_tbl[i];
			if (best == 0 || p < best_p) begin
				best = i;
				best_p = p;
			end
		end
		if (best == 0) return 0;
		if (ithreshold != 0 && best_p >= ithreshold) return 0;
		return (32'(best) << 16) | 32'(best_p & 8'hFF);
	endfunction

	function automatic void drop_pending(int w, logic [31:0] m);
		logic [31:0] c;
		if (w >= NUM_WORDS) return;
		c = ip_word[w] & m;
		ip_word[w] &= ~m;
		if (c != 0) begin
			eoi_w = w[0];
			eoi_m = c;
		end
	endfunction

	function automatic void raise_pending(int w, logic [31:0] m);
		if (w >= NUM_WORDS) return;
		for (int b = 0; b < 32; b++)
			if (m[b] && source_live(w * 32 + b)) ip_word[w][b] = 1'b1;
	endfunction

	function automatic logic [31:0] real_bits(int w);
		logic [31:0] m;
		m = 0;
		for (int b = 0; b < 32; b++)
			if (w * 32 + b != 0 && w * 32 + b < NUM_SOURCES) m[b] = 1'b1;
		return m;
	endfunction

	function automatic logic [31:0] reg_read(int off);
		int i, w;
		logic [31:0] r;
		r = 0;
		if (off == icdm_pkg::OFF_DOMAINCFG)
			return icdm_pkg::DOMAINCFG_FIXED | (32'(dom_ie) << icdm_pkg::DOMAINCFG_IE);
		if (off >= OFF_SOURCECFG && off < OFF_SOURCECFG + SPAN_SRC) begin
			i = (off - OFF_SOURCECFG) / 4 + 1;
			return (i < NUM_SOURCES) ? 32'(mode_tbl[i]) : 0;
		end
		if (off >= OFF_TARGET && off < OFF_TARGET + SPAN_SRC) begin
			i = (off - OFF_TARGET) / 4 + 1;
			return source_live(i) ? 32'(prio_tbl[i]) : 0;
		end
		if (off >= icdm_pkg::OFF_SETIP && off < icdm_pkg::OFF_SETIP + SPAN_WORDS) begin
			w = (off - icdm_pkg::OFF_SETIP) / 4;
			return (w < NUM_WORDS) ? ip_word[w] : 0;
		end
		if (off >= icdm_pkg::OFF_SETIE && off < icdm_pkg::OFF_SETIE + SPAN_WORDS) begin
			w = (off - icdm_pkg::OFF_SETIE) / 4;
			return (w < NUM_WORDS) ? ie_word[w] : 0;
		end
		if (off >= icdm_pkg::OFF_IN_CLRIP && off < icdm_pkg::OFF_IN_CLRIP + SPAN_WORDS) begin
			w = (off - icdm_pkg::OFF_IN_CLRIP) / 4;
			if (w >= NUM_WORDS) return 0;
			for (int b = 0; b < 32; b++) begin
				i = w * 32 + b;
				if (i == 0 || i >= NUM_SOURCES) continue;
				if ((mode_tbl[i] == icdm_pkg::MODE_LEVEL_HI
						|| mode_tbl[i] == icdm_pkg::MODE_LEVEL_LO)
						&& ip_word[w][b]) r[b] = 1'b1;
			end
			return r;
		end
		if (off >= icdm_pkg::OFF_IDC && off < icdm_pkg::OFF_IDC + 32) begin
			case (5'(off - icdm_pkg::OFF_IDC))
				icdm_pkg::IDC_IDELIVERY:  return 32'(idelivery);
				icdm_pkg::IDC_IFORCE:     return 32'(iforce);
				icdm_pkg::IDC_ITHRESHOLD: return 32'(ithreshold);
				icdm_pkg::IDC_TOPI:       return top_source();
				icdm_pkg::IDC_CLAIMI: begin
					r = top_source();
					if (r == 0) iforce = 1'b0;
					else drop_pending(r[31:16] / 32, 32'd1 << (r[31:16] % 32));
					return r;
				end
				default: return 0;
			endcase
		end
		return 0;
	endfunction

	function automatic void reg_write(int off, logic [31:0] val);
		int i, w;
		logic [2:0] sm;
		if (off == icdm_pkg::OFF_DOMAINCFG) begin
			dom_ie = val[icdm_pkg::DOMAINCFG_IE];
		end else if (off >= OFF_SOURCECFG && off < OFF_SOURCECFG + SPAN_SRC) begin
			i = (off - OFF_SOURCECFG) / 4 + 1;
			if (i < NUM_SOURCES) begin
				sm = val[2:0];
				// delegation or a reserved mode turns the source off
				if (val[icdm_pkg::DELEGATE_BIT] || sm == icdm_pkg::MODE_RSVD_A
						|| sm == icdm_pkg::MODE_RSVD_B)
					sm = icdm_pkg::MODE_INACTIVE;
				mode_tbl[i] = sm;
				if (sm == icdm_pkg::MODE_INACTIVE && i / 32 < NUM_WORDS) begin
					ip_word[i/32][i%32] = 1'b0;
					ie_word[i/32][i%32] = 1'b0;
				end
			end
		end else if (off >= OFF_TARGET && off < OFF_TARGET + SPAN_SRC) begin
			i = (off - OFF_TARGET) / 4 + 1;
			if (i < NUM_SOURCES) prio_tbl[i] = val[7:0];
		end else if (off >= icdm_pkg::OFF_SETIP && off < icdm_pkg::OFF_SETIP + SPAN_WORDS) begin
			raise_pending((off - icdm_pkg::OFF_SETIP) / 4, val);
		end else if (off >= icdm_pkg::OFF_IN_CLRIP
				&& off < icdm_pkg::OFF_IN_CLRIP + SPAN_WORDS) begin
			drop_pending((off - icdm_pkg::OFF_IN_CLRIP) / 4, val);
		end else if (off >= icdm_pkg::OFF_SETIE && off < icdm_pkg::OFF_SETIE + SPAN_WORDS) begin
			w = (off - icdm_pkg::OFF_SETIE) / 4;
			if (w < NUM_WORDS) ie_word[w] |= val & real_bits(w);
		end else if (off >= icdm_pkg::OFF_CLRIE && off < icdm_pkg::OFF_CLRIE + SPAN_WORDS) begin
			w = (off - icdm_pkg::OFF_CLRIE) / 4;
			if (w < NUM_WORDS) ie_word[w] &= ~val;
		end else if (off == icdm_pkg::OFF_SETIPNUM) begin
			if (val < NUM_SOURCES) raise_pending(val / 32, 32'd1 << (val % 32));
		end else if (off == icdm_pkg::OFF_CLRIPNUM) begin
			if (val != 0 && val < NUM_SOURCES) drop_pending(val / 32, 32'd1 << (val % 32));
		end else if (off == icdm_pkg::OFF_SETIENUM || off == icdm_pkg::OFF_CLRIENUM) begin
			if (val != 0 && val < NUM_SOURCES && val / 32 < NUM_WORDS) begin
				if (off == icdm_pkg::OFF_SETIENUM) ie_word[val/32][val%32] = 1'b1;
				else ie_word[val/32][val%32] = 1'b0;
			end
		end else if (off >= icdm_pkg::OFF_IDC && off < icdm_pkg::OFF_IDC + 32) begin
			case (5'(off - icdm_pkg::OFF_IDC))
				icdm_pkg::IDC_IDELIVERY:  idelivery = val[0];
				icdm_pkg::IDC_IFORCE:     iforce = val[0];
				icdm_pkg::IDC_ITHRESHOLD: ithreshold = val[7:0];
				default: ;
			endcase
		end
	endfunction

	function automatic icdm_pkg::rsp_t serve_request(icdm_pkg::req_t rq);
		icdm_pkg::rsp_t r;
		r = '0;
		eoi_w = 1'b0;
		eoi_m = 0;
		if (rq.kind == icdm_pkg::KIND_READ || rq.kind == icdm_pkg::KIND_WRITE) begin
			if (rq.access_size != icdm_pkg::ACCESS_BYTES || rq.offset[1:0] != 2'b00)
				r.access_fault = 1'b1;
			else if (rq.kind == icdm_pkg::KIND_READ) r.read_data = reg_read(rq.offset);
			else reg_write(rq.offset, rq.write_data);
		end else if (rq.kind == icdm_pkg::KIND_RAISE) begin
			if (rq.source != 0 && rq.source < NUM_SOURCES)
				raise_pending(rq.source / 32, 32'd1 << (rq.source % 32));
		end
		r.meip = dom_ie && idelivery && (top_source() != 0 || iforce);
		r.eoi_word = eoi_w;
		r.eoi_mask = eoi_m;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		icdm_pkg::rsp_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				mode_tbl[i] = icdm_pkg::MODE_INACTIVE;
				prio_tbl[i] = 8'd1;
			end
			for (int w = 0; w < NUM_WORDS; w++) begin
				ip_word[w] = 0;
				ie_word[w] = 0;
			end
			dom_ie = 0;
			idelivery = 0;
			iforce = 0;
			ithreshold = 0;
			expected_rsp.delete();
			fail_count = 0;
			result_count = 0;
			pending_count = 0;
		end else begin
			if (done) begin
				result_count++;
				if (expected_rsp.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result %h", $time, result);
				end else begin
					exp_r = expected_rsp.pop_front();
					if (result.read_data !== exp_r.read_data
							|| result.access_fault !== exp_r.access_fault
							|| result.meip !== exp_r.meip || result.eoi_word !== exp_r.eoi_word
							|| result.eoi_mask !== exp_r.eoi_mask) begin
						fail_count++;
						$display("%0t: result mismatch expected %h actual %h",
							$time, exp_r, result);
					end
				end
			end
			if (start && !busy) expected_rsp.push_back(serve_request(request));
			pending_count = expected_rsp.size();
		end
	end

endmodule

### tb/interrupt_controller_direct_mode_core_tb.sv
// stimulus and verdict for the direct-mode interrupt controller
// depends on icdm_pkg, the block and icdm_checker
`timescale 1ns / 100ps

module interrupt_controller_direct_mode_core_tb;

	localparam int NSRC = 64;
	localparam int NWRD = 2;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic clk, arst_n, start, busy, done;
	icdm_pkg::req_t request;
	icdm_pkg::rsp_t result;
	int fail_count, pending_count, result_count;
	int idle_cycles;
	int item_count;

	interrupt_controller_direct_mode_core #(.NUM_SOURCES(NSRC), .NUM_WORDS(NWRD)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .done(done), .result(result)
	);

	icdm_checker #(.NUM_SOURCES(NSRC), .NUM_WORDS(NWRD)) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .fail_count(fail_count),
		.pending_count(pending_count), .result_count(result_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: cycles with neither a request taken nor a result shown
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("end of test: mismatches");
			$finish;
		end
	end

	// hold one request on the port until the block takes it
	task automatic issue(icdm_pkg::req_t rq);
		request <= rq;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		item_count++;
	endtask

	// occasional random idle gap between requests, only when allowed
	task automatic maybe_idle(bit allow);
		int n;
		if (allow && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 13);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic icdm_pkg::req_t bus_op(logic [1:0] k, logic [14:0] off,
			logic [31:0] d);
		icdm_pkg::req_t rq;
		rq = '0;
		rq.kind = k;
		rq.offset = off;
		rq.access_size = icdm_pkg::ACCESS_BYTES;
		rq.write_data = d;
		rq.source = 10'($urandom);
		return rq;
	endfunction

	function automatic icdm_pkg::req_t raise_op(logic [9:0] s);
		icdm_pkg::req_t rq;
		rq = '0;
		rq.kind = icdm_pkg::KIND_RAISE;
		rq.source = s;
		rq.offset = 15'($urandom);
		rq.write_data = $urandom;
		rq.access_size = 3'($urandom);
		return rq;
	endfunction

	// offsets mostly aimed at real registers of the small source range
	function automatic logic [14:0] pick_offset();
		int s;
		s = $urandom_range(1, NSRC + 2);
		case ($urandom_range(0, 15))
			0: return icdm_pkg::OFF_DOMAINCFG;
			1, 2: return 15'(4 * s);
			3, 4: return 15'(15'h3000 + 4 * s);
			5: return 15'(icdm_pkg::OFF_SETIP + 4 * $urandom_range(0, 3));
			6: return 15'(icdm_pkg::OFF_IN_CLRIP + 4 * $urandom_range(0, 3));
			7: return 15'(icdm_pkg::OFF_SETIE + 4 * $urandom_range(0, 3));
			8: return 15'(icdm_pkg::OFF_CLRIE + 4 * $urandom_range(0, 3));
			9: return icdm_pkg::OFF_SETIPNUM;
			10: return icdm_pkg::OFF_CLRIPNUM;
			11: return ($urandom_range(0, 1)) ? icdm_pkg::OFF_SETIENUM : icdm_pkg::OFF_CLRIENUM;
			12, 13: return 15'(icdm_pkg::OFF_IDC + 4 * $urandom_range(0, 7));
			14: return 15'(4 * $urandom_range(0, 8191));
			default: return 15'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_data(logic [14:0] off);
		if (off == icdm_pkg::OFF_SETIPNUM || off == icdm_pkg::OFF_CLRIPNUM
				|| off == icdm_pkg::OFF_SETIENUM || off == icdm_pkg::OFF_CLRIENUM)
			return ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, NSRC + 2);
		if (off < 15'h1000 && $urandom_range(0, 1))
			return {$urandom} & 32'h0000_0407 | ($urandom_range(0, 3) == 0 ? $urandom : 0);
		if (off >= icdm_pkg::OFF_IDC && $urandom_range(0, 1)) return $urandom_range(0, 3);
		return $urandom;
	endfunction

	function automatic icdm_pkg::req_t random_req();
		icdm_pkg::req_t rq;
		logic [14:0] off;
		int r;
		r = $urandom_range(0, 19);
		if (r < 5) return raise_op(($urandom_range(0, 7) == 0) ? 10'($urandom)
			: 10'($urandom_range(0, NSRC)));
		off = pick_offset();
		rq = bus_op((r < 12) ? icdm_pkg::KIND_WRITE : icdm_pkg::KIND_READ, off, pick_data(off));
		if (r == 19) begin
			// faults, bad sizes and the unused kind
			rq.access_size = 3'($urandom);
			rq.offset = 15'($urandom);
			if ($urandom_range(0, 2) == 0) rq.kind = KIND_UNUSED;
		end
		return rq;
	endfunction

	initial begin
		icdm_pkg::req_t rq;
		int settle;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		item_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: build one deliverable interrupt and walk it through claim
		issue(bus_op(icdm_pkg::KIND_READ, icdm_pkg::OFF_DOMAINCFG, 0));
		issue(bus_op(icdm_pkg::KIND_WRITE, icdm_pkg::OFF_DOMAINCFG, 32'hFFFF_FFFF));
		issue(bus_op(icdm_pkg::KIND_WRITE, 15'h0004, 32'd6));        // source 1 level
		issue(bus_op(icdm_pkg::KIND_WRITE, 15'h00FC, 32'd4));        // edge-triggered mode for source 63
		issue(bus_op(icdm_pkg::KIND_WRITE, 15'h0008,
			32'd4 | (1 << icdm_pkg::DELEGATE_BIT)));                 // delegated
		issue(bus_op(icdm_pkg::KIND_WRITE, 15'h000C, 32'd2));        // reserved mode
		issue(bus_op(icdm_pkg::KIND_WRITE, 15'h3004, 32'd0));        // priority 0 acts as 1
		issue(bus_op(icdm_pkg::KIND_WRITE, 15'h30FC, 32'hFF));
		issue(bus_op(icdm_pkg::KIND_WRITE, icdm_pkg::OFF_SETIE, 32'hFFFF_FFFF));
		issue(bus_op(icdm_pkg::KIND_WRITE, 15'(icdm_pkg::OFF_SETIE + 4), 32'hFFFF_FFFF));
		issue(raise_op(10'd63));
		issue(raise_op(10'd0));
		issue(raise_op(10'h3FF));
		issue(bus_op(icdm_pkg::KIND_WRITE, icdm_pkg::OFF_SETIPNUM, 32'd1));
		issue(bus_op(icdm_pkg::KIND_WRITE,
			15'(icdm_pkg::OFF_IDC + icdm_pkg::IDC_IDELIVERY), 32'd1));
		issue(bus_op(icdm_pkg::KIND_READ, 15'(icdm_pkg::OFF_IDC + icdm_pkg::IDC_TOPI), 0));
		issue(bus_op(icdm_pkg::KIND_READ, icdm_pkg::OFF_IN_CLRIP, 0));
		issue(bus_op(icdm_pkg::KIND_READ, 15'(icdm_pkg::OFF_IDC + icdm_pkg::IDC_CLAIMI), 0));
		issue(bus_op(icdm_pkg::KIND_WRITE,
			15'(icdm_pkg::OFF_IDC + icdm_pkg::IDC_ITHRESHOLD), 32'hFF));
		issue(bus_op(icdm_pkg::KIND_WRITE,
			15'(icdm_pkg::OFF_IDC + icdm_pkg::IDC_IFORCE), 32'd1));
		// nothing wins: drops iforce
		issue(bus_op(icdm_pkg::KIND_READ, 15'(icdm_pkg::OFF_IDC + icdm_pkg::IDC_CLAIMI), 0));
		issue(bus_op(icdm_pkg::KIND_WRITE, icdm_pkg::OFF_CLRIPNUM, 32'd63));
		rq = bus_op(icdm_pkg::KIND_READ, 15'h7FFF, 0);
		rq.access_size = 3'd7;
		issue(rq);
		rq = bus_op(icdm_pkg::KIND_WRITE, 15'h0002, 32'hFFFF_FFFF);
		issue(rq);
		issue(bus_op(icdm_pkg::KIND_WRITE, icdm_pkg::OFF_CLRIE, 32'hFFFF_FFFF));

		// random phase, idling stops for the final stretch
		while (item_count < 925) begin
			issue(random_req());
			maybe_idle(item_count < 800);
		end
		start <= 1'b0;

		while (pending_count != 0) @(posedge clk);
		settle = 0;
		while (settle < 4 * NSRC + 16) begin
			@(posedge clk);
			settle++;
		end
		$display("%0d requests issued, %0d results checked, registers, raises and faults mixed",
			item_count, result_count);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

### sim.f
src/icdm_pkg.sv
src/icdm_ctrl.sv
src/icdm_dp.sv
src/interrupt_controller_direct_mode_core.sv
tb/icdm_checker.sv
tb/interrupt_controller_direct_mode_core_tb.sv
